// ===== hw/rtl/plist_pkg.sv =====
// Shared types and command codes for the positional list engine.
`timescale 1ns / 1ps

package plist_pkg;

    localparam int POS_W = 16;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_INS_POS  = 2'd0,
        CMD_REM_POS  = 2'd1,
        CMD_INS_BACK = 2'd2,
        CMD_REM_BACK = 2'd3
    } cmd_t;

    typedef struct packed {
        logic ins;
        logic rem;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/plist_cell.sv =====
// One list cell: holds an entry and one stage of the removal carry lane.
`timescale 1ns / 1ps

module plist_cell #(
    parameter int IW       = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                        clk,
    input  plist_pkg::cell_ctl_t        ctl,
    input  logic [IW-1:0]               idx,
    input  logic [plist_pkg::VAL_W-1:0] value_in,
    input  logic [plist_pkg::VAL_W-1:0] left_data,
    input  logic [plist_pkg::VAL_W-1:0] right_data,
    input  logic [plist_pkg::VAL_W-1:0] carry_in,
    output logic [plist_pkg::VAL_W-1:0] data,
    output logic [plist_pkg::VAL_W-1:0] carry
);
    import plist_pkg::*;

    localparam logic [IW-1:0] MY_IDX = CELL_IDX[IW-1:0];

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] carry_reg;
    logic             hit;
    logic             above;

    assign hit   = (idx == MY_IDX);
    assign above = (MY_IDX > idx);

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            if (hit)
                data_reg <= value_in;
            else if (above)
                data_reg <= left_data;
        end
        else if (ctl.rem && (hit || above))
        begin
            data_reg <= right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rem || ctl.shift)
        begin
            carry_reg <= (ctl.rem && hit) ? data_reg : carry_in;
        end
    end

    assign data  = data_reg;
    assign carry = carry_reg;

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: command decode, cell chain, result register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries kept in a chain of cells.
// Inserts, removes at the front and removes that miss need no drain pass: the
// whole chain shifts in the cycle the transaction is accepted and the result
// appears in the output register the next cycle. A remove at index k > 0 goes
// through a drain state, since the removed entry travels toward cell 0 along a
// carry lane one cell per cycle and is read out of cell 1. One transaction is
// in work at a time; a new one is accepted once the previous result has been
// taken or is being taken in that cycle. No clearing pass is needed after reset.
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              cmd,
    input  logic signed [plist_pkg::POS_W-1:0]      position,
    input  logic signed [plist_pkg::VAL_W-1:0]      value_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [plist_pkg::VAL_W-1:0]      value_out,
    output logic [$clog2(CAPACITY+1)-1:0]           entry_count,
    output logic                                    full_drop,
    output logic                                    remove_miss
);
    import plist_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    drain_reg, drain_next;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic [CW-1:0]    out_count_reg, out_count_next;
    logic             out_drop_reg, out_drop_next;
    logic             out_miss_reg, out_miss_next;

    logic [VAL_W-1:0] data_w  [CAPACITY];
    logic [VAL_W-1:0] carry_w [CAPACITY];

    cmd_t             op;
    cell_ctl_t        ctl;
    logic             go;
    logic             is_ins;
    logic             pos_front;
    logic             beyond;
    logic             full;
    logic             empty;
    logic             miss;
    logic [IW-1:0]    idx;

    assign op        = cmd_t'(cmd);
    assign is_ins    = (op == CMD_INS_POS) || (op == CMD_INS_BACK);
    assign pos_front = (position == '0) || position[POS_W-1];
    assign beyond    = CMPW'($unsigned(position)) >= CMPW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign miss      = empty || ((op == CMD_REM_POS) && !pos_front && beyond);

    always_comb
    begin
        if (is_ins)
        begin
            if (op == CMD_INS_BACK)
                idx = count_reg[IW-1:0];
            else if (pos_front)
                idx = '0;
            else if (beyond)
                idx = count_reg[IW-1:0];
            else
                idx = position[IW-1:0];
        end
        else
        begin
            if (op == CMD_REM_BACK)
                idx = IW'(count_reg - 1'b1);
            else if (pos_front)
                idx = '0;
            else
                idx = position[IW-1:0];
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign go        = in_valid && in_ready;
    assign ctl.ins   = go && is_ins && !full;
    assign ctl.rem   = go && !is_ins && !miss;
    assign ctl.shift = (state_reg == S_DRAIN);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_d;
        logic [VAL_W-1:0] right_d;
        logic [VAL_W-1:0] carry_d;

        if (i == 0)
        begin : g_first
            assign left_d = value_in;
        end
        else
        begin : g_left
            assign left_d = data_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
            assign carry_d = '0;
        end
        else
        begin : g_right
            assign right_d = data_w[i+1];
            assign carry_d = carry_w[i+1];
        end

        plist_cell #(
            .IW       (IW),
            .CELL_IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (idx),
            .value_in   (value_in),
            .left_data  (left_d),
            .right_data (right_d),
            .carry_in   (carry_d),
            .data       (data_w[i]),
            .carry      (carry_w[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_drop_next  = out_drop_reg;
        out_miss_next  = out_miss_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    if (ctl.ins)
                        count_next = count_reg + 1'b1;
                    else if (ctl.rem)
                        count_next = count_reg - 1'b1;
                    out_count_next = count_next;
                    out_drop_next  = is_ins && full;
                    out_miss_next  = !is_ins && miss;
                    out_value_next = '0;
                    if (ctl.rem && (idx != '0))
                    begin
                        drain_next = idx;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        if (ctl.rem)
                            out_value_next = data_w[0];
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 1'b1;
                if (drain_reg == IW'(1))
                begin
                    out_value_next = carry_w[1];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_drop_reg  <= out_drop_next;
        out_miss_reg  <= out_miss_next;
    end

    assign out_valid   = out_valid_reg;
    assign value_out   = out_value_reg;
    assign entry_count = out_count_reg;
    assign full_drop   = out_drop_reg;
    assign remove_miss = out_miss_reg;

endmodule

// ===== dv/plist_checker.sv =====
// Checker for the positional list engine: tracks the list and compares every result.
`timescale 1ns / 1ps

module plist_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic [1:0]                              cmd,
    input  logic signed [plist_pkg::POS_W-1:0]      position,
    input  logic signed [plist_pkg::VAL_W-1:0]      value_in,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [plist_pkg::VAL_W-1:0]      value_out,
    input  logic [$clog2(CAPACITY+1)-1:0]           entry_count,
    input  logic                                    full_drop,
    input  logic                                    remove_miss,
    output int                                      mismatch_count,
    output int                                      pending
);

    import plist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [CW-1:0]           count;
        logic                    drop;
        logic                    miss;
    } list_result_t;

    logic signed [VAL_W-1:0] cells [0:CAPACITY-1];
    int                      held;
    int                      fail_total;
    int                      result_idx;
    list_result_t            expected_results [$];

    function automatic list_result_t list_step(input cmd_t op,
                                               input logic signed [POS_W-1:0] pos,
                                               input logic signed [VAL_W-1:0] val);
        list_result_t r;
        int           idx;
        r = '0;
        if (op == CMD_INS_POS || op == CMD_INS_BACK) begin
            if (held >= CAPACITY) begin
                r.drop = 1'b1;
            end
            else begin
                if (op == CMD_INS_BACK)
                    idx = held;
                else if (pos <= 0 || held == 0)
                    idx = 0;
                else if (int'(pos) >= held)
                    idx = held;
                else
                    idx = int'(pos);
                for (int i = held; i > idx; i--)
                    cells[i] = cells[i-1];
                cells[idx] = val;
                held++;
            end
        end
        else begin
            idx = -1;
            if (held == 0)
                r.miss = 1'b1;
            else if (op == CMD_REM_BACK)
                idx = held - 1;
            else if (pos <= 0)
                idx = 0;
            else if (int'(pos) >= held)
                r.miss = 1'b1;
            else
                idx = int'(pos);
            if (idx >= 0) begin
                r.value = cells[idx];
                for (int i = idx; i + 1 < held; i++)
                    cells[i] = cells[i+1];
                held--;
            end
        end
        r.count = CW'(held);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input list_result_t exp);
        fail_total++;
        if (fail_total <= 10)
            $display({"ERROR: result %0d %s: exp value %0d count %0d drop %b miss %b,",
                      " got value %0d count %0d drop %b miss %b"},
                     result_idx, what, exp.value, exp.count, exp.drop, exp.miss,
                     value_out, entry_count, full_drop, remove_miss);
    endtask

    always @(posedge clk or negedge rst_n) begin
        list_result_t exp;
        if (!rst_n) begin
            held = 0;
            fail_total = 0;
            result_idx = 0;
            expected_results.delete();
            mismatch_count <= 0;
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("with nothing pending", '0);
                end
                else begin
                    exp = expected_results[0];
                    expected_results.delete(0);
                    if (value_out !== exp.value || entry_count !== exp.count ||
                        full_drop !== exp.drop || remove_miss !== exp.miss)
                        note_mismatch("mismatch", exp);
                end
                result_idx++;
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        list_step(cmd_t'(cmd), position, value_in));
            mismatch_count <= fail_total;
            pending <= expected_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the positional list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    import plist_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int N_RANDOM    = 1430;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 20;
    localparam int STALL_LEN   = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    cmd_t                    cmd_drv;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value_in;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [VAL_W-1:0] value_out;
    logic [CW-1:0]           entry_count;
    logic                    full_drop;
    logic                    remove_miss;
    int                      mismatch_count;
    int                      pending;
    int                      cycles;
    logic                    calm;
    logic                    stall_req;

    positional_list_engine #(.CAPACITY(CAPACITY)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd_drv),
        .position    (position),
        .value_in    (value_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_out   (value_out),
        .entry_count (entry_count),
        .full_drop   (full_drop),
        .remove_miss (remove_miss)
    );

    plist_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd_drv),
        .position       (position),
        .value_in       (value_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_out      (value_out),
        .entry_count    (entry_count),
        .full_drop      (full_drop),
        .remove_miss    (remove_miss),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Called and returns at a falling edge.
    task automatic send_cmd(input cmd_t op, input int pos, input logic [31:0] val);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd_drv  = op;
        position = POS_W'(pos);
        value_in = val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int hold_left;
        logic stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_done)
            begin
                hold_left  = STALL_LEN;
                stall_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = calm || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        int   ins_pct;
        int   sel;
        int   pos;
        cmd_t op;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd_drv   = CMD_INS_POS;
        position  = '0;
        value_in  = '0;
        calm      = 1'b0;
        stall_req = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list: removes miss, insert lands at the front
        send_cmd(CMD_REM_BACK, 0, 32'hFFFF_FFFF);
        send_cmd(CMD_REM_POS, 0, 32'h1234_5678);
        send_cmd(CMD_REM_POS, 32767, 32'hFFFF_FFFF);
        send_cmd(CMD_INS_POS, 5, 32'd10);
        send_cmd(CMD_INS_POS, -32768, 32'h8000_0000);
        send_cmd(CMD_INS_POS, 32767, 32'h7FFF_FFFF);
        send_cmd(CMD_INS_POS, 0, 32'hFFFF_FFFF);
        send_cmd(CMD_INS_POS, 2, 32'h5555_5555);
        send_cmd(CMD_INS_BACK, -1, 32'hAAAA_AAAA);
        send_cmd(CMD_INS_POS, 6, 32'd7);
        send_cmd(CMD_INS_POS, -1, 32'd3);
        // removes past the end miss, then removes take the list down to empty
        send_cmd(CMD_REM_POS, 8, 32'hFFFF_FFFF);
        send_cmd(CMD_REM_POS, 32767, 32'h0);
        send_cmd(CMD_REM_POS, -32768, 32'h0);
        send_cmd(CMD_REM_POS, 0, 32'hFFFF_FFFF);
        send_cmd(CMD_REM_POS, 5, 32'h0);
        send_cmd(CMD_REM_POS, 2, 32'h0);
        send_cmd(CMD_REM_BACK, 0, 32'h0);
        send_cmd(CMD_REM_POS, 1, 32'h0);
        send_cmd(CMD_REM_POS, -1, 32'h0);
        send_cmd(CMD_REM_BACK, 7, 32'h0);
        send_cmd(CMD_REM_BACK, 0, 32'h0);

        // phases alternate fill, drain and mixed so the list hits full and empty
        for (int n = 0; n < N_RANDOM; n++)
        begin
            case ((n / 120) % 3)
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            calm = (n >= 600 && n < 800);
            if (n == 150)
                stall_req = 1'b1;
            if ($urandom_range(0, 99) < ins_pct)
                op = $urandom_range(0, 1) ? CMD_INS_POS : CMD_INS_BACK;
            else
                op = $urandom_range(0, 1) ? CMD_REM_POS : CMD_REM_BACK;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                pos = $urandom_range(0, CAPACITY + 2);
            else if (sel < 7)
                pos = -int'($urandom_range(1, 4));
            else
                pos = $urandom_range(0, 65535);
            send_cmd(op, pos, $urandom());
        end
        in_valid = 1'b0;
        calm     = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
